// ===== hdl/csl_pkg.sv =====
// Package: shared types, constants and helpers for the C-subset lexer.
package csl_pkg;

    localparam int PositionBitsDefault = 32;
    localparam int ValueBitsDefault    = 63;

    localparam logic [2:0] KIND_NUMBER = 3'd0;
    localparam logic [2:0] KIND_IDENT  = 3'd1;
    localparam logic [2:0] KIND_SYMBOL = 3'd2;
    localparam logic [2:0] KIND_KEYWORD = 3'd3;
    localparam logic [2:0] KIND_STRING = 3'd4;
    localparam logic [2:0] KIND_STRBYTE = 3'd5;
    localparam logic [2:0] KIND_END    = 3'd6;
    localparam logic [2:0] KIND_ERROR  = 3'd7;

    localparam logic [1:0] ERR_STRING  = 2'd0;
    localparam logic [1:0] ERR_COMMENT = 2'd1;
    localparam logic [1:0] ERR_BADCHAR = 2'd2;

    localparam int NUM_KW = 9;

    // lexer modes, one-hot
    typedef enum logic [10:0] {
        M_IDLE  = 11'b00000000001,
        M_NUM   = 11'b00000000010,
        M_IDENT = 11'b00000000100,
        M_SYM   = 11'b00000001000,
        M_LINE  = 11'b00000010000,
        M_BLOCK = 11'b00000100000,
        M_BSTAR = 11'b00001000000,
        M_STR   = 11'b00010000000,
        M_ESC   = 11'b00100000000,
        M_DONE  = 11'b01000000000,
        M_ERR   = 11'b10000000000
    } lex_mode_t;

    // keyword table: length and character at index
    function automatic logic [2:0] kw_len(input logic [3:0] k);
        case (k)
            4'd0: kw_len = 3'd6;
            4'd1: kw_len = 3'd3;
            4'd2: kw_len = 3'd4;
            4'd3: kw_len = 3'd2;
            4'd4: kw_len = 3'd6;
            4'd5: kw_len = 3'd3;
            4'd6: kw_len = 3'd4;
            4'd7: kw_len = 3'd5;
            4'd8: kw_len = 3'd6;
            default: kw_len = 3'd0;
        endcase
    endfunction

    function automatic logic [47:0] kw_text(input logic [3:0] k);
        case (k)
            4'd0: kw_text = "nruter";
            4'd1: kw_text = {24'd0, "rof"};
            4'd2: kw_text = {16'd0, "esle"};
            4'd3: kw_text = {32'd0, "fi"};
            4'd4: kw_text = "foezis";
            4'd5: kw_text = {24'd0, "tni"};
            4'd6: kw_text = {16'd0, "rahc"};
            4'd7: kw_text = {8'd0, "elihw"};
            4'd8: kw_text = "tcurts";
            default: kw_text = 48'd0;
        endcase
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    // single-byte symbol index, 31 when not a symbol
    function automatic logic [4:0] single_symbol(input logic [7:0] c);
        case (c)
            "-": single_symbol = 5'd5;
            "+": single_symbol = 5'd6;
            "/": single_symbol = 5'd7;
            "*": single_symbol = 5'd8;
            "<": single_symbol = 5'd9;
            ">": single_symbol = 5'd10;
            "(": single_symbol = 5'd11;
            ")": single_symbol = 5'd12;
            ";": single_symbol = 5'd13;
            "=": single_symbol = 5'd14;
            "{": single_symbol = 5'd15;
            "}": single_symbol = 5'd16;
            "&": single_symbol = 5'd17;
            ",": single_symbol = 5'd18;
            "[": single_symbol = 5'd19;
            "]": single_symbol = 5'd20;
            ".": single_symbol = 5'd21;
            default: single_symbol = 5'd31;
        endcase
    endfunction

    // two-byte symbol index, 31 when no pair
    function automatic logic [4:0] pair_symbol(input logic [7:0] a, input logic [7:0] b);
        pair_symbol = 5'd31;
        if (a == "<" && b == "=") pair_symbol = 5'd0;
        if (a == ">" && b == "=") pair_symbol = 5'd1;
        if (a == "=" && b == "=") pair_symbol = 5'd2;
        if (a == "!" && b == "=") pair_symbol = 5'd3;
        if (a == "-" && b == ">") pair_symbol = 5'd4;
    endfunction

    function automatic logic [7:0] decode_escape(input logic [7:0] c);
        case (c)
            "a": decode_escape = 8'd7;
            "b": decode_escape = 8'd8;
            "t": decode_escape = 8'd9;
            "n": decode_escape = 8'd10;
            "v": decode_escape = 8'd11;
            "f": decode_escape = 8'd12;
            "r": decode_escape = 8'd13;
            "e": decode_escape = 8'd27;
            default: decode_escape = c;
        endcase
    endfunction

endpackage

// ===== hdl/csl_result_fifo.sv =====
// Result queue: holds token results until the receiver takes them.
module csl_result_fifo
    import csl_pkg::*;
#(
    parameter int Width = 8,
    parameter int Depth = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [Width-1:0] wr_data,
    output logic [$clog2(Depth+1)-1:0] free_count,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [Width-1:0] rd_data
);
    localparam int AW = $clog2(Depth);
    localparam int CW = $clog2(Depth + 1);

    logic [Width-1:0] mem_reg [Depth];
    logic [AW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic rd_fire;

    assign rd_valid   = (count_reg != '0);
    assign rd_fire    = rd_valid && rd_ready;
    assign rd_data    = mem_reg[rptr_reg];
    assign free_count = CW'(Depth) - count_reg;

    always_comb begin
        count_next = count_reg;
        if (wr_en && !rd_fire) count_next = count_reg + 1'b1;
        if (!wr_en && rd_fire) count_next = count_reg - 1'b1;
    end

    // storage
    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wptr_reg] <= wr_data;
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (wr_en) wptr_reg <= (wptr_reg == AW'(Depth - 1)) ? '0 : wptr_reg + 1'b1;
            if (rd_fire) rptr_reg <= (rptr_reg == AW'(Depth - 1)) ? '0 : rptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end
endmodule

// ===== hdl/c_subset_lexer_core.sv =====
// Top level: byte-serial C-subset lexer with a result queue.
//
// Source bytes enter on the s_ channel, one transaction per byte:
// s_axis_tdata[7:0] is the byte, s_axis_tlast marks the last byte of the
// source. Each byte gives zero to three results on the m_ channel; the token
// kind travels on m_axis_tuser and the last result of a byte carries
// m_axis_tlast.
// Per-byte work is one pass of combinational logic from the lexer state
// registers into a result register set holding up to three results; from
// there one result per cycle is written into an 8-deep result queue.
// The first result of a byte is registered in the result register set when
// the byte is accepted, then written into the queue, from which it can be taken;
// further results of the same byte follow one per cycle.
// Throughput: a byte giving zero or one result is taken every cycle while the
// queue has room; a byte giving more holds s_axis_tready low until only one of its results is left to write.
// When the receiver stalls the queue fills and s_axis_tready drops until
// room for the pending results plus a full three-result burst is free.
// Reset (aresetn low, synchronous) returns the lexer to idle at offset
// zero and empties the queue. The lexer also returns to reset state after
// every byte marked last.
module c_subset_lexer_core
    import csl_pkg::*;
#(
    parameter int POSITION_BITS = PositionBitsDefault,
    parameter int VALUE_BITS    = ValueBitsDefault
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // char_byte
    input  logic         s_axis_tlast,   // last_char
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // reserved_id[4:0], error_code[6:5], start_offset[38:7],
    // token_length[70:39], number_value[133:71], string_byte[141:134], pad
    output logic [143:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser,   // token_kind
    output logic         m_axis_tlast    // run_end
);
    localparam int RW  = 146;
    localparam int PB  = POSITION_BITS;
    localparam int VB  = VALUE_BITS;
    localparam int VB4 = VALUE_BITS + 4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  rid;
        logic [1:0]  ecode;
        logic [31:0] start;
        logic [31:0] len;
        logic [62:0] val;
        logic [7:0]  sb;
        logic        last;
    } res_t;

    lex_mode_t        mode_reg, mode_next;
    logic [PB-1:0]    pos_reg, pos_next, tstart_reg, tstart_next;
    logic [VB-1:0]    acc_reg, acc_next;
    logic [NUM_KW-1:0] kw_reg, kw_next;
    logic [7:0]       psym_reg, psym_next;

    res_t   res_next [3];
    res_t   res_reg  [3];
    logic [1:0] cnt_next, cnt_reg;
    logic [1:0] wslot_reg;

    logic   s_fire;
    logic [7:0] c;
    logic   lastc;

    // queue: result register drains one slot per cycle
    logic [3:0] free_count;
    logic       q_wr;
    res_t       q_in, q_out;
    logic       q_valid;

    assign c      = s_axis_tdata;
    assign lastc  = s_axis_tlast;
    // accept when at most the slot being written now is pending and the queue
    // can take it plus three more
    assign s_axis_tready = aresetn &&
        (((cnt_reg == 2'd0) && (free_count >= 4'd3)) ||
         ((cnt_reg == 2'd1) && (free_count >= 4'd4)));
    assign s_fire = s_axis_tvalid && s_axis_tready;

    // lexer next-state logic
    always_comb begin
        logic [PB-1:0] pos1, tlen, idx;
        logic [VB-1:0] vmax, d;
        logic [VB+3:0] acc10;
        logic [1:0] ec;
        logic fin;
        logic [PB-1:0] endpos;
        lex_mode_t m;
        logic err;
        logic [NUM_KW-1:0] kwc;
        logic kwfound;
        logic [3:0] kwidx;
        logic [47:0] kt;
        logic [7:0] kch;

        mode_next   = mode_reg;
        pos_next    = pos_reg;
        tstart_next = tstart_reg;
        acc_next    = acc_reg;
        kw_next     = kw_reg;
        psym_next   = psym_reg;
        cnt_next    = 2'd0;
        for (int i = 0; i < 3; i++) res_next[i] = '0;
        pos1   = pos_reg + 1'b1;
        vmax   = '1;
        d      = VB'(c - "0");
        acc10  = '0;
        ec     = '0;
        fin    = 1'b0;
        endpos = pos1;
        m      = mode_reg;
        err    = 1'b0;
        kwc    = kw_reg;
        kwfound = 1'b0;
        kwidx  = '0;
        kt     = '0;
        kch    = '0;
        tlen   = '0;
        idx    = pos_reg - tstart_reg;

        if (mode_reg != M_DONE && mode_reg != M_ERR) begin
            if (c == 8'd0) begin
                fin = 1'b1;
                endpos = pos_reg;
            end else begin
                // feed: may flush a token, then begin a new one
                logic begin_tok;
                begin_tok = 1'b0;
                case (mode_reg)
                    M_IDLE: begin_tok = 1'b1;
                    M_NUM: begin
                        if (is_digit(c)) begin
                            // acc * 10 + d, saturating at the all-ones value
                            acc10 = VB4'({acc_reg, 3'b000}) + VB4'({acc_reg, 1'b0}) +
                                    VB4'(d);
                            acc_next = (acc10 > VB4'(vmax)) ? vmax : acc10[VB-1:0];
                        end else begin
                            res_next[ec] = '{KIND_NUMBER, 5'd0, 2'd0, 32'(tstart_reg),
                                32'(pos_reg - tstart_reg), 63'(acc_reg), 8'd0, 1'b0};
                            ec = ec + 1'b1;
                            begin_tok = 1'b1;
                        end
                    end
                    M_IDENT: begin
                        if (is_alpha(c) || is_digit(c)) begin
                            for (int j = 0; j < NUM_KW; j++) begin
                                kt  = kw_text(4'(j));
                                kch = 8'(kt >> {idx[2:0], 3'b000});
                                if (idx >= PB'(kw_len(4'(j))) || kch != c)
                                    kw_next[j] = 1'b0;
                            end
                        end else begin
                            tlen = pos_reg - tstart_reg;
                            for (int j = NUM_KW - 1; j >= 0; j--) begin
                                if (kw_reg[j] && PB'(kw_len(4'(j))) == tlen) begin
                                    kwfound = 1'b1;
                                    kwidx = 4'(j);
                                end
                            end
                            res_next[ec] = '{kwfound ? KIND_KEYWORD : KIND_IDENT,
                                kwfound ? 5'(kwidx) : 5'd0, 2'd0, 32'(tstart_reg),
                                32'(tlen), 63'd0, 8'd0, 1'b0};
                            ec = ec + 1'b1;
                            begin_tok = 1'b1;
                        end
                    end
                    M_SYM: begin
                        if (psym_reg == "/" && c == "/") mode_next = M_LINE;
                        else if (psym_reg == "/" && c == "*") mode_next = M_BLOCK;
                        else if (pair_symbol(psym_reg, c) != 5'd31) begin
                            res_next[ec] = '{KIND_SYMBOL, pair_symbol(psym_reg, c), 2'd0,
                                32'(tstart_reg), 32'd2, 63'd0, 8'd0, 1'b0};
                            ec = ec + 1'b1;
                            mode_next = M_IDLE;
                        end else if (psym_reg == "!") begin
                            res_next[ec] = '{KIND_ERROR, 5'd0, ERR_BADCHAR, 32'(tstart_reg),
                                32'd0, 63'd0, 8'd0, 1'b0};
                            ec = ec + 1'b1;
                            mode_next = M_ERR;
                        end else begin
                            res_next[ec] = '{KIND_SYMBOL, single_symbol(psym_reg), 2'd0,
                                32'(tstart_reg), 32'd1, 63'd0, 8'd0, 1'b0};
                            ec = ec + 1'b1;
                            begin_tok = 1'b1;
                        end
                    end
                    M_LINE:  if (c == 8'd10) mode_next = M_IDLE;
                    M_BLOCK: if (c == "*") mode_next = M_BSTAR;
                    M_BSTAR: begin
                        if (c == "/") mode_next = M_IDLE;
                        else if (c != "*") mode_next = M_BLOCK;
                    end
                    M_STR: begin
                        if (c == "\"") begin
                            res_next[ec] = '{KIND_STRING, 5'd0, 2'd0, 32'(tstart_reg),
                                32'(pos1 - tstart_reg), 63'd0, 8'd0, 1'b0};
                            ec = ec + 1'b1;
                            mode_next = M_IDLE;
                        end else if (c == 8'd10) begin
                            res_next[ec] = '{KIND_ERROR, 5'd0, ERR_STRING,
                                32'(PB'(tstart_reg + 1'b1)), 32'd0, 63'd0, 8'd0, 1'b0};
                            ec = ec + 1'b1;
                            mode_next = M_ERR;
                        end else if (c == "\\") mode_next = M_ESC;
                        else begin
                            res_next[ec] = '{KIND_STRBYTE, 5'd0, 2'd0, 32'(pos_reg),
                                32'd1, 63'd0, c, 1'b0};
                            ec = ec + 1'b1;
                        end
                    end
                    M_ESC: begin
                        res_next[ec] = '{KIND_STRBYTE, 5'd0, 2'd0,
                            32'(PB'(pos_reg - 1'b1)), 32'd2, 63'd0, decode_escape(c), 1'b0};
                        ec = ec + 1'b1;
                        mode_next = M_STR;
                    end
                    default: ;
                endcase
                // start of a new token
                if (begin_tok) begin
                    mode_next = M_IDLE;
                    if (!is_space(c)) begin
                        tstart_next = pos_reg;
                        if (is_digit(c)) begin
                            mode_next = M_NUM;
                            acc_next = d;
                        end else if (c == "\"") mode_next = M_STR;
                        else if (is_alpha(c)) begin
                            mode_next = M_IDENT;
                            for (int j = 0; j < NUM_KW; j++) begin
                                kt = kw_text(4'(j));
                                kw_next[j] = (kt[7:0] == c);
                            end
                        end else if (c == "<" || c == ">" || c == "=" || c == "!" ||
                                     c == "-" || c == "/") begin
                            mode_next = M_SYM;
                            psym_next = c;
                        end else if (single_symbol(c) != 5'd31) begin
                            res_next[ec] = '{KIND_SYMBOL, single_symbol(c), 2'd0,
                                32'(pos_reg), 32'd1, 63'd0, 8'd0, 1'b0};
                            ec = ec + 1'b1;
                        end else begin
                            res_next[ec] = '{KIND_ERROR, 5'd0, ERR_BADCHAR, 32'(pos_reg),
                                32'd0, 63'd0, 8'd0, 1'b0};
                            ec = ec + 1'b1;
                            mode_next = M_ERR;
                        end
                    end
                end
                fin = lastc && (mode_next != M_ERR);
                endpos = pos1;
            end

            // end of source: flush the pending token from the updated state, then add an end result when no error
            if (fin) begin
                m = (c == 8'd0) ? mode_reg : mode_next;
                tlen = endpos - tstart_next;
                case (m)
                    M_NUM: begin
                        res_next[ec] = '{KIND_NUMBER, 5'd0, 2'd0, 32'(tstart_next),
                            32'(tlen), 63'(acc_next), 8'd0, 1'b0};
                        ec = ec + 1'b1;
                    end
                    M_IDENT: begin
                        kwc = kw_next;
                        kwfound = 1'b0;
                        kwidx = '0;
                        for (int j = NUM_KW - 1; j >= 0; j--) begin
                            if (kwc[j] && PB'(kw_len(4'(j))) == tlen) begin
                                kwfound = 1'b1;
                                kwidx = 4'(j);
                            end
                        end
                        res_next[ec] = '{kwfound ? KIND_KEYWORD : KIND_IDENT,
                            kwfound ? 5'(kwidx) : 5'd0, 2'd0, 32'(tstart_next),
                            32'(tlen), 63'd0, 8'd0, 1'b0};
                        ec = ec + 1'b1;
                    end
                    M_SYM: begin
                        if (psym_next == "!") begin
                            err = 1'b1;
                            res_next[ec] = '{KIND_ERROR, 5'd0, ERR_BADCHAR,
                                32'(tstart_next), 32'd0, 63'd0, 8'd0, 1'b0};
                        end else
                            res_next[ec] = '{KIND_SYMBOL, single_symbol(psym_next), 2'd0,
                                32'(tstart_next), 32'd1, 63'd0, 8'd0, 1'b0};
                        ec = ec + 1'b1;
                    end
                    M_BLOCK, M_BSTAR: begin
                        err = 1'b1;
                        res_next[ec] = '{KIND_ERROR, 5'd0, ERR_COMMENT, 32'(tstart_next),
                            32'd0, 63'd0, 8'd0, 1'b0};
                        ec = ec + 1'b1;
                    end
                    M_STR, M_ESC: begin
                        err = 1'b1;
                        res_next[ec] = '{KIND_ERROR, 5'd0, ERR_STRING,
                            32'(PB'(tstart_next + 1'b1)), 32'd0, 63'd0, 8'd0, 1'b0};
                        ec = ec + 1'b1;
                    end
                    default: ;
                endcase
                if (!err && ec < 2'd3) begin
                    res_next[ec] = '{KIND_END, 5'd0, 2'd0, 32'(endpos), 32'd0, 63'd0,
                        8'd0, 1'b0};
                    ec = ec + 1'b1;
                end
                mode_next = err ? M_ERR : M_DONE;
            end
        end

        if (ec != 2'd0) res_next[ec - 2'd1].last = 1'b1;
        cnt_next = ec;
        pos_next = pos1;
        if (lastc) begin
            mode_next   = M_IDLE;
            pos_next    = '0;
            tstart_next = '0;
            acc_next    = '0;
            kw_next     = '1;
            psym_next   = '0;
        end
    end

    // lexer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            tstart_reg <= '0;
            acc_reg    <= '0;
            kw_reg     <= '1;
            psym_reg   <= '0;
        end else if (s_fire) begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            tstart_reg <= tstart_next;
            acc_reg    <= acc_next;
            kw_reg     <= kw_next;
            psym_reg   <= psym_next;
        end
    end

    // result register and slot drain counter
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int i = 0; i < 3; i++) res_reg[i] <= res_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            wslot_reg <= '0;
        end else if (s_fire) begin
            cnt_reg   <= cnt_next;
            wslot_reg <= '0;
        end else if (cnt_reg != 2'd0) begin
            cnt_reg   <= cnt_reg - 1'b1;
            wslot_reg <= wslot_reg + 1'b1;
        end
    end

    assign q_wr = (cnt_reg != 2'd0);
    assign q_in = res_reg[wslot_reg];

    csl_result_fifo #(
        .Width(RW),
        .Depth(8)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (q_wr),
        .wr_data   (q_in),
        .free_count(free_count),
        .rd_valid  (q_valid),
        .rd_ready  (m_axis_tready),
        .rd_data   (q_out)
    );

    assign m_axis_tvalid = q_valid;
    assign m_axis_tdata  = {2'd0, q_out.sb, q_out.val, q_out.len, q_out.start,
                            q_out.ecode, q_out.rid};
    assign m_axis_tuser  = q_out.kind;
    assign m_axis_tlast  = q_out.last;
endmodule
